/* sv/mths_pkg.sv */
// shared types, constants and field widths for the monotone table hunt search unit
`default_nettype none
package mths_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	// index registers hold 0..depth
	localparam int IDX_W       = TABLE_AW + 1;
	// hunt step size can reach twice the depth
	localparam int INC_W       = IDX_W + 1;

	// field widths
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int ENTRY_IDX_W     = 10;
	localparam int GUESS_W         = 11;
	localparam int FOUND_W         = 11;
	localparam int SIZE_W          = 11;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

	// op codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// register addresses
	localparam logic [PADDR_W-1:0] ADDR_TABLE_SIZE = 3'd0;

	// read address select
	typedef enum logic [2:0] {
		RD_ZERO,
		RD_LAST,
		RD_LO,
		RD_HI,
		RD_MID
	} rd_sel_t;

	// index register updates
	typedef enum logic [3:0] {
		DP_NONE,
		DP_FULL,
		DP_GUESS,
		DP_UP_START,
		DP_DN_START,
		DP_UP_STEP,
		DP_DN_STEP,
		DP_BIS,
		DP_NEG
	} dp_op_t;

	typedef struct packed {
		logic    load;
		logic    wr;
		logic    key0_ld;
		logic    ascnd_ld;
		logic    out_ld;
		rd_sel_t rd_sel;
		dp_op_t  op;
	} cmd_t;

	typedef struct packed {
		logic pre_first;
		logic hint;
		logic up_dir;
		logic gt_dir;
		logic lt_dir;
		logic lo_last;
		logic lo_zero;
		logic up_over;
		logic dn_over;
		logic more;
	} sts_t;

endpackage
`default_nettype wire

/* sv/mths_dp.sv */
// datapath: table memory, index registers, comparators and result register
`default_nettype none
module mths_dp #(
	parameter int VALUE_WIDTH = mths_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire mths_pkg::cmd_t                      cmd,
	output mths_pkg::sts_t                           sts,
	input  wire logic [mths_pkg::ENTRY_IDX_W-1:0]    entry_index,
	input  wire logic signed [VALUE_WIDTH-1:0]       entry_value,
	input  wire logic signed [VALUE_WIDTH-1:0]       search_value,
	input  wire logic [mths_pkg::GUESS_W-1:0]        start_guess,
	input  wire logic [mths_pkg::SIZE_W-1:0]         table_size,
	output logic [mths_pkg::FOUND_W-1:0]             found_index
);

	localparam int AW = mths_pkg::TABLE_AW;
	localparam int IW = mths_pkg::IDX_W;
	localparam int CW = mths_pkg::INC_W;
	localparam int GW = mths_pkg::GUESS_W;
	localparam int SW = mths_pkg::SIZE_W;
	localparam int FW = mths_pkg::FOUND_W;

	logic signed [VALUE_WIDTH-1:0] mem [mths_pkg::TABLE_DEPTH];
	logic signed [VALUE_WIDTH-1:0] rdata_q;
	logic signed [VALUE_WIDTH-1:0] key0_q;
	logic signed [VALUE_WIDTH-1:0] x_q;

	logic [IW-1:0] n_q, lo_q, hi_q, guess_q;
	logic [CW-1:0] inc_q;
	logic          ascnd_q, hint_q, neg_q;
	logic [FW-1:0] found_q;

	logic [IW-1:0] n_next, n_last, mid, dn_lo;
	logic [IW:0]   mid_sum;
	logic [CW-1:0] inc2;
	logic [CW:0]   up_sum;
	logic [AW-1:0] rd_addr;
	logic          hint_next, ascnd_now;

	// clamp the size in use to 1..depth
	always_comb begin
		if (table_size == '0) begin
			n_next = IW'(1);
		end else if (table_size > SW'(mths_pkg::TABLE_DEPTH)) begin
			n_next = IW'(mths_pkg::TABLE_DEPTH);
		end else begin
			n_next = IW'(table_size);
		end
	end

	// guess usable when non-negative and below the size
	assign hint_next = !start_guess[GW-1] && (IW'(start_guess[GW-2:0]) < n_next);

	// index arithmetic
	assign n_last  = n_q - IW'(1);
	assign mid_sum = (IW+1)'(lo_q) + (IW+1)'(hi_q);
	assign mid     = mid_sum[IW:1];
	assign inc2    = {inc_q[CW-2:0], 1'b0};
	assign up_sum  = (CW+1)'(lo_q) + (CW+1)'(inc2);
	assign dn_lo   = lo_q - IW'(inc2);

	// table direction from first and last entries in use
	assign ascnd_now = (rdata_q >= key0_q);

	// status to controller
	always_comb begin
		sts.pre_first = ascnd_now ? (x_q < key0_q) : (x_q > key0_q);
		sts.hint      = hint_q;
		sts.up_dir    = ((x_q >= rdata_q) == ascnd_q);
		sts.gt_dir    = ((x_q > rdata_q) == ascnd_q);
		sts.lt_dir    = ((x_q < rdata_q) == ascnd_q);
		sts.lo_last   = (lo_q == n_last);
		sts.lo_zero   = (lo_q == '0);
		sts.up_over   = (up_sum > (CW+1)'(n_last));
		sts.dn_over   = (inc2 >= CW'(lo_q));
		sts.more      = ((hi_q - lo_q) > IW'(1));
	end

	// read address select
	always_comb begin
		case (cmd.rd_sel)
			mths_pkg::RD_ZERO: rd_addr = '0;
			mths_pkg::RD_LAST: rd_addr = n_last[AW-1:0];
			mths_pkg::RD_LO:   rd_addr = lo_q[AW-1:0];
			mths_pkg::RD_HI:   rd_addr = hi_q[AW-1:0];
			mths_pkg::RD_MID:  rd_addr = mid[AW-1:0];
			default:           rd_addr = '0;
		endcase
	end

	// table memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[entry_index[AW-1:0]] <= entry_value;
		end
		rdata_q <= mem[rd_addr];
	end

	// operand capture and index updates
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= search_value;
			n_q     <= n_next;
			guess_q <= IW'(start_guess[GW-2:0]);
			hint_q  <= hint_next;
			neg_q   <= 1'b0;
		end
		if (cmd.key0_ld) begin
			key0_q <= rdata_q;
		end
		if (cmd.ascnd_ld) begin
			ascnd_q <= ascnd_now;
		end
		case (cmd.op)
			mths_pkg::DP_FULL: begin
				lo_q <= '0;
				hi_q <= n_q;
			end
			mths_pkg::DP_GUESS: begin
				lo_q  <= guess_q;
				inc_q <= CW'(1);
			end
			mths_pkg::DP_UP_START: begin
				hi_q <= lo_q + IW'(1);
			end
			mths_pkg::DP_DN_START: begin
				hi_q <= lo_q;
				lo_q <= lo_q - IW'(1);
			end
			mths_pkg::DP_UP_STEP: begin
				inc_q <= inc2;
				hi_q  <= sts.up_over ? n_q : IW'(up_sum);
			end
			mths_pkg::DP_DN_STEP: begin
				inc_q <= inc2;
				hi_q  <= lo_q;
				lo_q  <= sts.dn_over ? '0 : dn_lo;
			end
			mths_pkg::DP_BIS: begin
				if (sts.gt_dir) begin
					lo_q <= mid;
				end else begin
					hi_q <= mid;
				end
			end
			mths_pkg::DP_NEG: begin
				neg_q <= 1'b1;
			end
			default: begin
			end
		endcase
		// result register
		if (cmd.out_ld) begin
			found_q <= neg_q ? '1 : FW'(lo_q);
		end
	end

	assign found_index = found_q;

endmodule
`default_nettype wire

/* sv/mths_ctrl.sv */
// controller: sequences table reads for the hunt and bisection, owns the handshakes
`default_nettype none
module mths_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           op,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire mths_pkg::sts_t sts,
	output mths_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RDN,
		S_CHK,
		S_GRD,
		S_GCMP,
		S_URD,
		S_UCMP,
		S_DRD,
		S_DCMP,
		S_BRD,
		S_BCMP,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.wr       = 1'b0;
		cmd.key0_ld  = 1'b0;
		cmd.ascnd_ld = 1'b0;
		cmd.out_ld   = 1'b0;
		cmd.rd_sel   = mths_pkg::RD_ZERO;
		cmd.op       = mths_pkg::DP_NONE;
		case (state_q)
			S_IDLE: begin
				// first entry is read while idle
				if (in_valid) begin
					if (op == mths_pkg::OP_WRITE) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = S_RDN;
					end
				end
			end
			S_RDN: begin
				cmd.key0_ld = 1'b1;
				cmd.rd_sel  = mths_pkg::RD_LAST;
				state_d     = S_CHK;
			end
			S_CHK: begin
				cmd.ascnd_ld = 1'b1;
				if (sts.pre_first) begin
					cmd.op  = mths_pkg::DP_NEG;
					state_d = S_DONE;
				end else if (sts.hint) begin
					cmd.op  = mths_pkg::DP_GUESS;
					state_d = S_GRD;
				end else begin
					cmd.op  = mths_pkg::DP_FULL;
					state_d = S_BRD;
				end
			end
			S_GRD: begin
				cmd.rd_sel = mths_pkg::RD_LO;
				state_d    = S_GCMP;
			end
			S_GCMP: begin
				// pick hunt direction from the guess entry
				if (sts.up_dir) begin
					if (sts.lo_last) begin
						state_d = S_DONE;
					end else begin
						cmd.op  = mths_pkg::DP_UP_START;
						state_d = S_URD;
					end
				end else begin
					if (sts.lo_zero) begin
						state_d = S_DONE;
					end else begin
						cmd.op  = mths_pkg::DP_DN_START;
						state_d = S_DRD;
					end
				end
			end
			S_URD: begin
				cmd.rd_sel = mths_pkg::RD_HI;
				state_d    = S_UCMP;
			end
			S_UCMP: begin
				if (sts.gt_dir) begin
					cmd.op  = mths_pkg::DP_UP_STEP;
					state_d = sts.up_over ? S_BRD : S_URD;
				end else begin
					state_d = S_BRD;
				end
			end
			S_DRD: begin
				cmd.rd_sel = mths_pkg::RD_LO;
				state_d    = S_DCMP;
			end
			S_DCMP: begin
				if (sts.lt_dir) begin
					cmd.op  = mths_pkg::DP_DN_STEP;
					state_d = sts.dn_over ? S_BRD : S_DRD;
				end else begin
					state_d = S_BRD;
				end
			end
			S_BRD: begin
				cmd.rd_sel = mths_pkg::RD_MID;
				state_d    = sts.more ? S_BCMP : S_DONE;
			end
			S_BCMP: begin
				cmd.op  = mths_pkg::DP_BIS;
				state_d = S_BRD;
			end
			S_DONE: begin
				// wait for a free result register
				if (!out_valid_q || !out_stall) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* sv/monotone_table_hunt_search_unit.sv */
// Monotone table hunt search unit: holds a sorted Q16.16 table and brackets search values.
// Input channel (in_valid / in_stall): op selects a table write (entry_index,
// entry_value) or a search (search_value, start_guess). A write transaction returns nothing.
// A search transaction returns one found_index on the
// output channel (out_valid / out_stall): the lower bracketing index, or -1 when the
// value lies before the first entry.
// A search makes its table reads through the single registered memory read port.
// Input is stalled while a search runs.
// Writes are accepted back to back at one per cycle while no search runs.
// The result register decouples the sides: a new transaction is taken while a
// result waits; a finishing search holds until the result register frees up.
// Reset clears the controller and sets table_size to 1024; table entries are
// undefined until written. table_size is set over the APB port at address 0; the user
// must write it only while the unit is idle, which the block itself does not enforce.
`default_nettype none
module monotone_table_hunt_search_unit #(
	parameter int VALUE_WIDTH = mths_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                op,
	input  wire logic [mths_pkg::ENTRY_IDX_W-1:0]    entry_index,
	input  wire logic signed [VALUE_WIDTH-1:0]       entry_value,
	input  wire logic signed [VALUE_WIDTH-1:0]       search_value,
	input  wire logic signed [mths_pkg::GUESS_W-1:0] start_guess,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [mths_pkg::FOUND_W-1:0]      found_index,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [mths_pkg::PADDR_W-1:0]        paddr,
	input  wire logic [mths_pkg::PDATA_W-1:0]        pwdata,
	output logic [mths_pkg::PDATA_W-1:0]             prdata,
	output logic                                     pready
);

	localparam int SW = mths_pkg::SIZE_W;
	localparam int FW = mths_pkg::FOUND_W;

	mths_pkg::cmd_t cmd;
	mths_pkg::sts_t sts;

	logic [SW-1:0] size_q;
	logic          size_wr;

	// configuration register
	assign pready  = 1'b1;
	assign size_wr = psel && penable && pwrite && (paddr == mths_pkg::ADDR_TABLE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= mths_pkg::SIZE_RESET;
		end else if (size_wr) begin
			size_q <= pwdata[SW-1:0];
		end
	end

	assign prdata = (paddr == mths_pkg::ADDR_TABLE_SIZE) ? mths_pkg::PDATA_W'(size_q) : '0;

	// controller
	mths_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	mths_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.sts          (sts),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.search_value (search_value),
		.start_guess  (start_guess),
		.table_size   (size_q),
		.found_index  (found_index)
	);

`ifndef SYNTHESIS
	// table write only on an accepted write transaction
	a_wr_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (in_valid && !in_stall && (op == mths_pkg::OP_WRITE)))
		else $error("table write without an accepted write transaction");

	// a new result always follows a busy search
	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> (out_valid && $past(in_stall)))
		else $error("result loaded outside a search");

	// result is -1 or an index below the size in use
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((found_index == {FW{1'b1}}) ||
			(!found_index[FW-1] && ((size_q == '0) || (SW'(found_index) < size_q)))))
		else $error("found_index outside -1..size-1");
`endif

endmodule
`default_nettype wire

/* dv/monotone_table_hunt_search_unit_tb.sv */
// testbench for the monotone table hunt search unit: table loads, searches and size settings
`timescale 1ns / 100ps
module monotone_table_hunt_search_unit_tb;
	import mths_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 64;
	localparam int HOLD_LEN    = 300;

	typedef enum int {
		SHAPE_ASC,
		SHAPE_DESC,
		SHAPE_FLAT,
		SHAPE_NOISE
	} shape_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic                        op;
	logic [ENTRY_IDX_W-1:0]      entry_index;
	logic signed [31:0]          entry_value;
	logic signed [31:0]          search_value;
	logic signed [GUESS_W-1:0]   start_guess;
	logic                        out_valid;
	logic                        out_stall;
	logic signed [FOUND_W-1:0]   found_index;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [PADDR_W-1:0]          paddr;
	logic [PDATA_W-1:0]          pwdata;
	logic [PDATA_W-1:0]          prdata;
	logic                        pready;

	// shadow of the block state
	logic signed [31:0]          entry_shadow [TABLE_DEPTH];
	logic [SIZE_W-1:0]           size_shadow = SIZE_RESET;
	logic signed [FOUND_W-1:0]   pending_found [$];

	int tx_max = 0;
	int rx_max = 0;
	int hold_req = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	monotone_table_hunt_search_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.search_value (search_value),
		.start_guess  (start_guess),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found_index  (found_index),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// number of entries the search really uses
	function automatic int active_size();
		int n;
		n = int'(size_shadow);
		if (n < 1) n = 1;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		return n;
	endfunction

	// hunt from the hint in doubling steps, then bisect
	function automatic logic signed [FOUND_W-1:0] bracket_index(logic signed [31:0] x,
			logic [GUESS_W-1:0] g);
		int  n, last, lo, hi, step, mid, hint;
		bit  rising;
		n = active_size();
		last = n - 1;
		rising = entry_shadow[last] >= entry_shadow[0];
		if (rising ? (x < entry_shadow[0]) : (x > entry_shadow[0]))
			return -1;
		hint = g[GUESS_W-1] ? -1 : int'(g);
		if (hint < 0 || hint >= n) begin
			lo = 0;
			hi = n;
		end else begin
			lo = hint;
			step = 1;
			if ((x >= entry_shadow[lo]) == rising) begin
				// hunt up
				if (lo == last)
					return FOUND_W'(lo);
				hi = lo + 1;
				while ((x > entry_shadow[hi]) == rising) begin
					step += step;
					hi = lo + step;
					if (hi > last) begin
						hi = n;
						break;
					end
				end
			end else begin
				// hunt down
				if (lo == 0)
					return 0;
				hi = lo;
				lo = lo - 1;
				while ((x < entry_shadow[lo]) == rising) begin
					hi = lo;
					step *= 2;
					if (step >= hi) begin
						lo = 0;
						break;
					end
					lo = hi - step;
				end
			end
		end
		while (hi - lo > 1) begin
			mid = (hi + lo) / 2;
			if ((x > entry_shadow[mid]) == rising)
				lo = mid;
			else
				hi = mid;
		end
		return FOUND_W'(lo);
	endfunction

	task automatic report_error(string what, logic signed [FOUND_W-1:0] want,
			logic signed [FOUND_W-1:0] got);
		error_count++;
		if (error_count <= 10)
			$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
	endtask

	// offer one transaction, record the prediction once it is taken
	task automatic send_item(logic o, logic [ENTRY_IDX_W-1:0] idx, logic signed [31:0] ev,
			logic signed [31:0] sv, logic [GUESS_W-1:0] g);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= o;
		entry_index <= idx;
		entry_value <= ev;
		search_value <= sv;
		start_guess <= g;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (o == OP_WRITE)
			entry_shadow[idx] = ev;
		else
			pending_found.push_back(bracket_index(sv, g));
	endtask

	task automatic put_entry(int idx, logic signed [31:0] val);
		send_item(OP_WRITE, ENTRY_IDX_W'(idx), val, $urandom, GUESS_W'($urandom));
	endtask

	task automatic put_search(logic signed [31:0] x, logic [GUESS_W-1:0] g);
		send_item(OP_SEARCH, ENTRY_IDX_W'($urandom), $urandom, x, g);
	endtask

	// stop offering, wait for every result and let the block go quiet
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_found.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_table_size(logic [PDATA_W-1:0] val);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_TABLE_SIZE;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_shadow = val[SIZE_W-1:0];
	endtask

	// write entries 0..size-1 with a table of the given shape
	task automatic load_table(shape_t shape);
		int                 n;
		longint             acc;
		longint             lim;
		logic signed [31:0] flat;
		logic signed [31:0] v;
		n = active_size();
		lim = 64'd4000000000 / n;
		acc = -64'sd2147483648 + longint'($urandom_range(1, 4096));
		flat = $urandom;
		for (int i = 0; i < n; i++) begin
			case (shape)
				SHAPE_FLAT:  v = flat;
				SHAPE_NOISE: v = $urandom;
				default:     v = acc[31:0];
			endcase
			put_entry((shape == SHAPE_DESC) ? n - 1 - i : i, v);
			case ($urandom_range(0, 3))
				0: acc += 0;
				3: acc += longint'($urandom_range(0, 32'(lim)));
				default: acc += longint'($urandom_range(1, 65536));
			endcase
			if (acc > 64'sd2147483647) acc = 64'sd2147483647;
		end
	endtask

	// one setting: size write, table load, then searches with some stray writes
	task automatic run_phase(logic [PDATA_W-1:0] size_val, int count, shape_t shape);
		int                 n, r, j;
		logic signed [31:0] x;
		logic [GUESS_W-1:0] g;
		set_table_size(size_val);
		tx_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
		rx_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
		load_table(shape);
		n = active_size();
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				put_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);
			end else if (r < 14) begin
				put_search($urandom, GUESS_W'($urandom));
			end else begin
				j = $urandom_range(0, n - 1);
				case ($urandom_range(0, 4))
					0: x = entry_shadow[j] + 1;
					1: x = entry_shadow[j] - 1;
					2: x = $urandom;
					default: x = entry_shadow[j];
				endcase
				case ($urandom_range(0, 19))
					0, 1, 2:    g = GUESS_W'(-int'($urandom_range(1, 1024)));
					3, 4, 5:    g = (n == TABLE_DEPTH) ? GUESS_W'(-1) :
						GUESS_W'($urandom_range(n, TABLE_DEPTH - 1));
					6, 7, 8, 9: g = GUESS_W'($urandom_range(0, n - 1));
					default:    g = GUESS_W'(j + int'($urandom_range(0, 6)) - 3);
				endcase
				put_search(x, g);
			end
		end
	endtask

	// full depth in use on a sparse table: only entries each search reads are written
	task automatic test_directed();
		tx_max = 2;
		rx_max = 16;
		put_entry(0, -32'sd1000000);
		put_entry(1, -32'sd500000);
		put_entry(2, -32'sd500000);
		put_entry(TABLE_DEPTH - 3, 32'sd400000);
		put_entry(TABLE_DEPTH - 2, 32'sd600000);
		put_entry(TABLE_DEPTH - 1, 32'sd800000);
		// value ahead of the first entry, with and without a hint
		put_search(-32'sd1000001, GUESS_W'(-1));
		put_search(32'sh8000_0000, GUESS_W'(2));
		// hint on the last index, at or beyond the last entry
		put_search(32'sh7FFF_FFFF, GUESS_W'(TABLE_DEPTH - 1));
		put_search(32'sd800000, GUESS_W'(TABLE_DEPTH - 1));
		// short hunt down near the top
		put_search(32'sd700000, GUESS_W'(TABLE_DEPTH - 1));
		put_search(32'sd500000, GUESS_W'(TABLE_DEPTH - 2));
		// hunt up that runs past the last index
		put_search(32'sh7FFF_FFFF, GUESS_W'(TABLE_DEPTH - 3));
		// hunt down that reaches index zero
		put_search(-32'sd600000, GUESS_W'(2));
		// ties go to the lower index
		put_search(-32'sd1000000, GUESS_W'(0));
		put_search(-32'sd500000, GUESS_W'(1));
		put_search(-32'sd500000, GUESS_W'(0));
		// most negative entry and search value
		put_entry(0, 32'sh8000_0000);
		put_search(32'sh8000_0000, GUESS_W'(0));
		put_search(32'sh8000_0000, GUESS_W'(1));
		// size above the depth is clamped to the depth
		set_table_size(2047);
		put_search(32'sh7FFF_FFFF, GUESS_W'(TABLE_DEPTH - 3));
		put_search(32'sh7FFF_FFFF, GUESS_W'(TABLE_DEPTH - 1));
		put_search(32'sd700000, GUESS_W'(TABLE_DEPTH - 1));
	endtask

	// receiver holds off while the sender keeps offering, then the sender waits
	task automatic test_backpressure();
		int n;
		n = active_size();
		tx_max = 0;
		hold_req = HOLD_LEN;
		for (int k = 0; k < 12; k++)
			put_search(entry_shadow[$urandom_range(0, n - 1)], GUESS_W'($urandom));
		wait_idle();
	endtask

	task automatic test_size_extremes();
		run_phase(1, 30, SHAPE_ASC);
		run_phase(0, 20, SHAPE_DESC);
		run_phase(2, 30, SHAPE_ASC);
		run_phase(2, 20, SHAPE_DESC);
	endtask

	task automatic test_random_sizes();
		shape_t shape;
		run_phase(3, 30, SHAPE_FLAT);
		run_phase(17, 50, SHAPE_DESC);
		run_phase(100, 80, SHAPE_ASC);
		for (int p = 0; p < 4; p++) begin
			case ($urandom_range(0, 5))
				0:       shape = SHAPE_NOISE;
				1:       shape = SHAPE_FLAT;
				2, 3:    shape = SHAPE_DESC;
				default: shape = SHAPE_ASC;
			endcase
			run_phase($urandom_range(4, 120), 40, shape);
		end
	endtask

	// result checking and output stall pattern
	initial begin : result_side
		int                        wait_left;
		int                        hold_left;
		logic signed [FOUND_W-1:0] want;
		wait_left = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_found.size() == 0) begin
					report_error("result with nothing pending", 'x, found_index);
				end else begin
					want = pending_found.pop_front();
					if (found_index !== want)
						report_error("found_index", want, found_index);
				end
				wait_left = $urandom_range(0, rx_max);
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (wait_left > 0) begin
				wait_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no transaction on any port
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pwrite))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("monotone_table_hunt_search_unit_tb: errors");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_WRITE;
		entry_index <= '0;
		entry_value <= '0;
		search_value <= '0;
		start_guess <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_extremes();
		test_random_sizes();
		test_backpressure();
		wait_idle();
		if (error_count == 0)
			$display("monotone_table_hunt_search_unit_tb: clean");
		else
			$display("monotone_table_hunt_search_unit_tb: errors");
		$finish;
	end

endmodule

/* files.f */
sv/mths_pkg.sv
sv/mths_dp.sv
sv/mths_ctrl.sv
sv/monotone_table_hunt_search_unit.sv
dv/monotone_table_hunt_search_unit_tb.sv
